@@ design/tcpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants of the three-class priority queue: request and
// response payloads, kind and status codes, store geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned NumLines   = 3;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned StoreDepth = NumLines * QueueDepth;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned LineW      = 2;
  localparam int unsigned TicketW    = 16;
  localparam int unsigned CountW     = 5;
  localparam int unsigned TotalW     = 6;

  localparam logic [LineW-1:0] LineA = 2'd0;
  localparam logic [LineW-1:0] LineB = 2'd1;
  localparam logic [LineW-1:0] LineC = 2'd2;

  typedef enum logic [1:0] {
    KindArrive    = 2'd0,
    KindServeLine = 2'd1,
    KindServeTop  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StServed   = 2'd0,
    StEmpty    = 2'd1,
    StEnqueued = 2'd2,
    StDropped  = 2'd3
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic [LineW-1:0]   line_select;
    logic [TicketW-1:0] ticket_in;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [TicketW-1:0] ticket_out;
    logic [LineW-1:0]   served_line;
    logic [CountW-1:0]  count_a;
    logic [CountW-1:0]  count_b;
    logic [CountW-1:0]  count_c;
    logic [TotalW-1:0]  count_total;
  } rsp_t;

  // Decision for one request: store access plus the response fields.
  typedef struct packed {
    status_e            status;
    logic [LineW-1:0]   line;
    logic [CountW-1:0]  count_a;
    logic [CountW-1:0]  count_b;
    logic [CountW-1:0]  count_c;
    logic [TotalW-1:0]  count_total;
    logic               served;
    logic               wr_en;
    logic               rd_en;
    logic [AddrW-1:0]   addr;
  } op_t;

endpackage

`default_nettype wire

@@ design/three_class_priority_queue.sv @@
// ----------------------------------------------------------------------------
// three_class_priority_queue
// Three FIFO lines of tickets (A highest, C lowest) in one ticket store.
//
// Request channel (req_valid_i/req_ready_o, req_i): arrive appends a ticket
// to a line, serve-line pops a chosen line, serve-top pops the highest
// non-empty line. Response channel (rsp_valid_o/rsp_ready_i, rsp_o): one
// response per request with status, popped ticket and the line counts after
// the request.
// Pipeline: the store read and the decoded request are registered at the
// accepting edge, the response register when the read stage advances.
// Throughput: one request per cycle while responses are taken. Pointers and
// counts sit in flops, the store takes at most one access per request, so
// requests do not interlock; a write is visible to a read the cycle after.
// Reset: all lines empty, pointers zero; no store clearing is needed since
// only written slots are ever read.
// Stall: a held response keeps one more request in the read stage; after
// that req_ready_o drops until the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module three_class_priority_queue
  import tcpq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  wire req_t req_i,
  output logic      rsp_valid_o,
  input  wire logic rsp_ready_i,
  output rsp_t      rsp_o
);

  logic               fire;
  op_t                op;
  logic [TicketW-1:0] store_mem [StoreDepth];
  logic [TicketW-1:0] rdata_q;
  logic               s1_valid_q, s1_valid_d;
  op_t                s1_op_q;
  logic               s1_adv;
  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q;

  tcpq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .fire_i (fire),
    .op_o   (op)
  );

  assign s1_adv      = s1_valid_q && (!rsp_valid_q || rsp_ready_i);
  assign req_ready_o = !s1_valid_q || s1_adv;
  assign fire        = req_valid_i && req_ready_o;

  // Ticket store: at most one access per accepted request, registered read.
  always_ff @(posedge clk_i) begin
    if (fire && op.wr_en) begin
      store_mem[op.addr] <= req_i.ticket_in;
    end
    if (fire && op.rd_en) begin
      rdata_q <= store_mem[op.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_op_q <= op;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (s1_adv) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Drop the stale read data unless this request popped a ticket.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rsp_q.status      <= s1_op_q.status;
      rsp_q.ticket_out  <= s1_op_q.served ? rdata_q : '0;
      rsp_q.served_line <= s1_op_q.line;
      rsp_q.count_a     <= s1_op_q.count_a;
      rsp_q.count_b     <= s1_op_q.count_b;
      rsp_q.count_c     <= s1_op_q.count_c;
      rsp_q.count_total <= s1_op_q.count_total;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

@@ design/tcpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Keeps head pointer and fill count of each line, decodes a request into a
// store read or write and the response fields, and updates on acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_ctrl
  import tcpq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire req_t req_i,
  input  wire logic fire_i,
  output op_t       op_o
);

  logic [CntW-1:0] cnt_q  [NumLines];
  logic [CntW-1:0] cnt_d  [NumLines];
  logic [PtrW-1:0] head_q [NumLines];
  logic [PtrW-1:0] head_d [NumLines];

  logic             sel_ok;
  logic [CntW-1:0]  sel_cnt;
  logic [PtrW-1:0]  sel_head;
  logic [CntW:0]    tail_sum;
  logic [PtrW-1:0]  tail_ptr;
  logic             pop_en;
  logic [LineW-1:0] pop_line;
  logic [CntW-1:0]  pop_cnt;
  logic [PtrW-1:0]  pop_head;
  logic [PtrW-1:0]  pop_next;

  assign sel_ok = req_i.line_select < LineW'(NumLines);

  always_comb begin
    sel_cnt  = '0;
    sel_head = '0;
    if (sel_ok) begin
      sel_cnt  = cnt_q[req_i.line_select];
      sel_head = head_q[req_i.line_select];
    end
  end

  // Tail slot: head plus count, wrapped into the ring.
  always_comb begin
    tail_sum = (CntW+1)'(sel_head) + (CntW+1)'(sel_cnt);
    if (tail_sum >= (CntW+1)'(QueueDepth)) begin
      tail_sum = tail_sum - (CntW+1)'(QueueDepth);
    end
    tail_ptr = PtrW'(tail_sum);
  end

  always_comb begin
    op_o     = '0;
    op_o.status = StEmpty;
    cnt_d    = cnt_q;
    head_d   = head_q;
    pop_en   = 1'b0;
    pop_line = LineA;
    pop_cnt  = '0;
    pop_head = '0;
    pop_next = '0;

    unique case (req_i.kind)
      KindArrive: begin
        op_o.status = StDropped;
        if (sel_ok) begin
          op_o.line = req_i.line_select;
          if (sel_cnt < CntW'(QueueDepth)) begin
            op_o.status = StEnqueued;
            op_o.wr_en  = 1'b1;
            op_o.addr   = AddrW'(AddrW'(req_i.line_select) * AddrW'(QueueDepth)
                                 + AddrW'(tail_ptr));
            cnt_d[req_i.line_select] = sel_cnt + CntW'(1);
          end
        end
      end
      KindServeLine: begin
        if (sel_ok && sel_cnt != '0) begin
          pop_en   = 1'b1;
          pop_line = req_i.line_select;
        end
      end
      KindServeTop: begin
        priority if (cnt_q[LineA] != '0) begin
          pop_en   = 1'b1;
          pop_line = LineA;
        end else if (cnt_q[LineB] != '0) begin
          pop_en   = 1'b1;
          pop_line = LineB;
        end else if (cnt_q[LineC] != '0) begin
          pop_en   = 1'b1;
          pop_line = LineC;
        end
      end
      default: begin
        op_o.status = StEmpty;
      end
    endcase

    if (pop_en) begin
      pop_cnt  = cnt_q[pop_line];
      pop_head = head_q[pop_line];
      pop_next = (pop_head == PtrW'(QueueDepth - 1)) ? '0 : pop_head + PtrW'(1);
      op_o.status  = StServed;
      op_o.line    = pop_line;
      op_o.served  = 1'b1;
      op_o.rd_en   = 1'b1;
      op_o.addr    = AddrW'(AddrW'(pop_line) * AddrW'(QueueDepth) + AddrW'(pop_head));
      cnt_d[pop_line]  = pop_cnt - CntW'(1);
      head_d[pop_line] = pop_next;
    end

    op_o.count_a     = CountW'(cnt_d[LineA]);
    op_o.count_b     = CountW'(cnt_d[LineB]);
    op_o.count_c     = CountW'(cnt_d[LineC]);
    op_o.count_total = TotalW'(TotalW'(cnt_d[LineA]) + TotalW'(cnt_d[LineB])
                               + TotalW'(cnt_d[LineC]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLines; i++) begin
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
      end
    end else if (fire_i) begin
      cnt_q  <= cnt_d;
      head_q <= head_d;
    end
  end

endmodule

`default_nettype wire
